>>> design/hwe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hebbian weight engine package
// Shared sizes, operation and status codes, and the divider handshake types.
// ----------------------------------------------------------------------------
package hwe_pkg;

	localparam int MAX_NEURONS  = 64;
	localparam int MAX_PATTERNS = 64;

	// Fixed field widths of the ports.
	localparam int OP_W   = 2;
	localparam int PAT_W  = 64;
	localparam int IDX_W  = 6;
	localparam int SUM_W  = 8;
	localparam int WGT_W  = 22;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 7;

	localparam logic [CFG_W-1:0] NCOUNT_RESET = 7'd64;
	localparam int Q_FRAC = 14;

	// Derived sizes.
	localparam int NIDX_W  = $clog2(MAX_NEURONS);
	localparam int PADDR_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int CNT_W   = $clog2(MAX_PATTERNS + 1);
	localparam int MAG_W   = CNT_W;
	localparam int QUO_W   = MAG_W + Q_FRAC;
	localparam int DCNT_W  = $clog2(QUO_W + 1);

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] mag;
		logic [CFG_W-1:0] divisor;
	} hwe_div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quot;
	} hwe_div_rsp_t;

endpackage
`default_nettype wire

>>> design/hwe_pat_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern store
// One word per stored pattern, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hwe_pat_mem
	import hwe_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [PADDR_W-1:0]     wr_addr,
	input  wire logic [MAX_NEURONS-1:0] wr_data,
	input  wire logic                   rd_en,
	input  wire logic [PADDR_W-1:0]     rd_addr,
	output logic      [MAX_NEURONS-1:0] rd_data
);

	logic [MAX_NEURONS-1:0] mem_q [MAX_PATTERNS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> design/hwe_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial weight divider
// Restoring division of (mag << Q_FRAC) by the neuron count, one bit a cycle.
// ----------------------------------------------------------------------------
module hwe_serial_div
	import hwe_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire hwe_div_req_t req,
	output hwe_div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [CFG_W:0]    rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CFG_W-1:0]  div_q;

	logic [CFG_W:0]    trial;
	logic              qbit;
	logic [CFG_W:0]    rem_nxt;

	// The dividend shifts out of the top of quo_q while quotient bits enter below.
	always_comb begin
		trial   = {rem_q[CFG_W-1:0], quo_q[QUO_W-1]};
		qbit    = (trial >= {1'b0, div_q});
		rem_nxt = qbit ? (trial - {1'b0, div_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DCNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= {req.mag, {Q_FRAC{1'b0}}};
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QUO_W-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule
`default_nettype wire

>>> design/hebbian_weight_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hebbian weight engine
// Stores +1/-1 patterns and answers Hopfield coupling weight queries.
// ----------------------------------------------------------------------------
// Clear and load items finish in the cycle they are accepted, and their result
// appears in the output register on the next cycle. A query that is in range,
// off the diagonal and has P > 0 stored patterns goes through two steps:
// the stored patterns are scanned one word per cycle through the single read
// port of the pattern memory, whose read data is registered, and the
// weight is then produced by a restoring divider that settles one quotient bit
// per cycle. Other queries finish at once. The block works on one
// item at a time; a finished result waits in the output register, and the next
// item can be taken in the same cycle that the result is transferred. Clear
// only resets the pattern count: memory words above the count are never read,
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
module hebbian_weight_engine_top
	import hwe_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_W-1:0]        cfg_wr_data,

	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic [PAT_W-1:0]        pattern_bits,
	input  wire logic [IDX_W-1:0]        row_index,
	input  wire logic [IDX_W-1:0]        col_index,

	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [SUM_W-1:0]      overlap_sum,
	output logic signed [WGT_W-1:0]      weight_fixed,
	output logic [STAT_W-1:0]            status
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                  st_q;
	logic [CFG_W-1:0]        ncount_q;
	logic [CNT_W-1:0]        stored_cnt_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] sum_out_q;
	logic signed [WGT_W-1:0] wgt_out_q;
	logic [STAT_W-1:0]       stat_out_q;

	// Query context.
	logic [NIDX_W-1:0]       row_q;
	logic [NIDX_W-1:0]       col_q;
	logic [CNT_W-1:0]        scan_idx_q;
	logic [CNT_W-1:0]        diff_q;
	logic                    neg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    rd_vld_s1;
	logic                    rd_last_s1;

	logic [CFG_W-1:0]        n_eff;
	logic                    out_free;
	logic                    in_xfer;
	logic                    full;
	logic                    go_scan;
	logic                    mem_wr;
	logic [STAT_W-1:0]       imm_status;
	logic                    issue;
	logic [CNT_W-1:0]        idx_nxt;
	logic [MAX_NEURONS-1:0]  rd_data;
	logic                    pbit;
	logic [CNT_W-1:0]        diff_fin;
	logic signed [CNT_W+1:0] s_full;
	logic signed [CNT_W+1:0] s_abs;
	logic                    fin_write;
	logic [QUO_W:0]          w_mag;
	logic [QUO_W:0]          w_val;
	hwe_div_req_t            div_req;
	hwe_div_rsp_t            div_rsp;

	// A count of zero behaves as one; anything above the array size is clamped.
	always_comb begin
		if (ncount_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (ncount_q > CFG_W'(MAX_NEURONS)) begin
			n_eff = CFG_W'(MAX_NEURONS);
		end else begin
			n_eff = ncount_q;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (st_q == ST_IDLE) && out_free;
	assign in_xfer  = in_valid && in_ready;
	assign full     = (stored_cnt_q >= CNT_W'(MAX_PATTERNS));

	// Decode of an accepted item. Everything but a query that needs the scan
	// produces its result directly.
	always_comb begin
		go_scan    = 1'b0;
		mem_wr     = 1'b0;
		imm_status = STAT_OK;
		unique case (op)
			OP_CLEAR: begin
				imm_status = STAT_OK;
			end
			OP_LOAD: begin
				if (full) begin
					imm_status = STAT_FULL;
				end else begin
					mem_wr = in_xfer;
				end
			end
			OP_QUERY: begin
				if (({1'b0, row_index} >= n_eff) || ({1'b0, col_index} >= n_eff)) begin
					imm_status = STAT_RANGE;
				end else if ((row_index != col_index) && (stored_cnt_q != '0)) begin
					go_scan = 1'b1;
				end
			end
			default: begin
				imm_status = STAT_OK;
			end
		endcase
	end

	// Scan: one pattern word is read per cycle; the XOR of the two selected
	// neuron bits counts the patterns where the pair disagrees.
	assign issue   = (st_q == ST_SCAN) && (scan_idx_q < stored_cnt_q);
	assign idx_nxt = scan_idx_q + CNT_W'(1);

	hwe_pat_mem u_pat_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (stored_cnt_q[PADDR_W-1:0]),
		.wr_data (pattern_bits[MAX_NEURONS-1:0]),
		.rd_en   (issue),
		.rd_addr (scan_idx_q[PADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign pbit     = rd_data[row_q] ^ rd_data[col_q];
	assign diff_fin = diff_q + CNT_W'(pbit);

	// Overlap = count - 2 * disagreements, and its magnitude for the divider.
	always_comb begin
		s_full = $signed({2'b00, stored_cnt_q}) - $signed({1'b0, diff_fin, 1'b0});
		s_abs  = (s_full < 0) ? -s_full : s_full;
	end

	assign div_req.start   = rd_vld_s1 && rd_last_s1;
	assign div_req.mag     = s_abs[MAG_W-1:0];
	assign div_req.divisor = n_eff;

	hwe_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign fin_write = (((st_q == ST_DIV) && div_rsp.done) || (st_q == ST_DONE)) && out_free;
	assign w_mag     = {1'b0, div_rsp.quot};
	assign w_val     = neg_q ? (~w_mag + (QUO_W+1)'(1)) : w_mag;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			ncount_q     <= NCOUNT_RESET;
			stored_cnt_q <= '0;
			out_valid_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ncount_q <= cfg_wr_data;
			end

			rd_vld_s1  <= issue;
			rd_last_s1 <= issue && (idx_nxt == stored_cnt_q);

			if (in_xfer && (op == OP_CLEAR)) begin
				stored_cnt_q <= '0;
			end else if (mem_wr) begin
				stored_cnt_q <= stored_cnt_q + CNT_W'(1);
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer && go_scan) begin
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (div_req.start) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						st_q <= out_free ? ST_IDLE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			if ((in_xfer && !go_scan) || fin_write) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and query context.
	always_ff @(posedge clk) begin
		if (in_xfer && go_scan) begin
			row_q      <= row_index[NIDX_W-1:0];
			col_q      <= col_index[NIDX_W-1:0];
			scan_idx_q <= '0;
			diff_q     <= '0;
		end else begin
			if (issue) begin
				scan_idx_q <= idx_nxt;
			end
			if (rd_vld_s1) begin
				diff_q <= diff_fin;
			end
		end

		if (div_req.start) begin
			neg_q <= (s_full < 0);
			sum_q <= SUM_W'(s_full);
		end

		if (in_xfer && !go_scan) begin
			sum_out_q  <= '0;
			wgt_out_q  <= '0;
			stat_out_q <= imm_status;
		end else if (fin_write) begin
			sum_out_q  <= sum_q;
			wgt_out_q  <= WGT_W'($signed(w_val));
			stat_out_q <= STAT_OK;
		end
	end

	assign out_valid    = out_valid_q;
	assign overlap_sum  = sum_out_q;
	assign weight_fixed = wgt_out_q;
	assign status       = stat_out_q;

	// The pattern count never passes the size of the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		stored_cnt_q <= CNT_W'(MAX_PATTERNS))
		else $error("pattern count beyond store size");

	// A load into a full store leaves the count untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (op == OP_LOAD) && full) |=> $stable(stored_cnt_q))
		else $error("load into full store changed the count");

	// Read data returns only while a scan is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (st_q == ST_SCAN))
		else $error("pattern read outside of a scan");

	// The divider only finishes while a query waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (st_q == ST_DIV))
		else $error("divider finished outside of a query");

endmodule
`default_nettype wire

>>> tb/hebbian_weight_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hebbian weight engine testbench
// Drives clear, load and query transfers with random idling on both channels.
// Each transfer's result is predicted from a local copy of the pattern store.
// Results are checked in order; the neuron count is changed between phases.
// ----------------------------------------------------------------------------
module hebbian_weight_engine_top_tb;
	import hwe_pkg::*;

	// Slowest correct run: about 2100 items, each a full-store query plus the
	// longest sender gap and the longest receiver stall; the watchdog limit
	// below leaves a wide margin over that.
	localparam int LIMIT_CYCLES  = 2000000;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int HOLD_CYCLES   = 300;
	// Extra idle time after the final drain, before the verdict is printed.
	localparam int DRAIN_CYCLES  = 120;

	localparam logic [PAT_W-1:0] ALT_EVEN = 64'h5555_5555_5555_5555;
	localparam logic [PAT_W-1:0] ALT_ODD  = 64'hAAAA_AAAA_AAAA_AAAA;

	// One expected result transfer.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic signed [WGT_W-1:0] weight;
		logic [STAT_W-1:0]       stat;
	} weight_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_W-1:0]        cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [OP_W-1:0]         op;
	logic [PAT_W-1:0]        pattern_bits;
	logic [IDX_W-1:0]        row_index;
	logic [IDX_W-1:0]        col_index;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SUM_W-1:0] overlap_sum;
	logic signed [WGT_W-1:0] weight_fixed;
	logic [STAT_W-1:0]       status;

	// Local copy of the engine state: the transposed pattern store, the
	// number of stored patterns and the neuron count register.
	logic [PAT_W-1:0] column_words [MAX_NEURONS];
	int               pattern_total;
	logic [CFG_W-1:0] neuron_setting;

	// Results still owed by the engine, oldest first.
	weight_result_t   pending_results [$];

	int               mismatch_count;
	int               cycle_count;
	// Receiver hold-off, counted down in the receiver process.
	int               hold_left;
	int               stall_left;
	// When set, neither side idles.
	bit               steady_flow;

	hebbian_weight_engine_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.pattern_bits (pattern_bits),
		.row_index    (row_index),
		.col_index    (col_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.overlap_sum  (overlap_sum),
		.weight_fixed (weight_fixed),
		.status       (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// The divisor the engine really uses: zero acts as one, and anything
	// above the array size acts as the array size.
	function automatic int active_neurons();
		int n;
		n = int'(neuron_setting);
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_NEURONS) begin
			n = MAX_NEURONS;
		end
		return n;
	endfunction

	// Applies one accepted transfer to the local store and returns the result
	// that the engine must produce for it.
	function automatic weight_result_t step_engine(input logic [OP_W-1:0] op_code,
			input logic [PAT_W-1:0] bits, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		weight_result_t res;
		logic [PAT_W-1:0] live_mask;
		int n;
		int diff;
		int s;
		int mag;
		int q;
		res = '0;
		case (op_code)
			OP_CLEAR: begin
				for (int j = 0; j < MAX_NEURONS; j++) begin
					column_words[j] = '0;
				end
				pattern_total = 0;
			end
			OP_LOAD: begin
				if (pattern_total >= MAX_PATTERNS) begin
					res.stat = STAT_FULL;
				end else begin
					for (int j = 0; j < MAX_NEURONS; j++) begin
						column_words[j][pattern_total] = bits[j];
					end
					pattern_total++;
				end
			end
			OP_QUERY: begin
				n = active_neurons();
				if (row >= n || col >= n) begin
					res.stat = STAT_RANGE;
				end else if (row != col) begin
					live_mask = (pattern_total >= 64) ? '1 : ((64'd1 << pattern_total) - 64'd1);
					diff = $countones((column_words[row] ^ column_words[col]) & live_mask);
					s = pattern_total - 2 * diff;
					mag = (s < 0) ? -s : s;
					q = (mag << Q_FRAC) / n;
					res.sum = s[SUM_W-1:0];
					res.weight = WGT_W'((s < 0) ? -q : q);
				end
			end
			default: begin
				// The spare op code leaves the store alone and reports zeros.
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (steady_flow) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PAT_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Patterns of one sequence cluster around a base word, so that overlap
	// sums spread over the whole range rather than hugging zero.
	function automatic logic [PAT_W-1:0] related_pattern(input logic [PAT_W-1:0] base);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return base ^ (random_word() & random_word() & random_word());
		end else if (r < 6) begin
			return ~base;
		end else if (r < 9) begin
			return random_word();
		end
		return $urandom_range(0, 1) ? '1 : '0;
	endfunction

	function automatic logic [CFG_W-1:0] random_neuron_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			return 7'd64;
		end else if (r < 35) begin
			return 7'd0;
		end else if (r < 45) begin
			return 7'd1;
		end else if (r < 55) begin
			return 7'd127;
		end else if (r < 65) begin
			return 7'd2;
		end
		return CFG_W'($urandom_range(3, 127));
	endfunction

	// Offers one item and waits for its transfer. Valid stays high after the
	// transfer so that a following item can go out back to back; anything
	// else that follows lowers it first.
	task automatic send_item(input logic [OP_W-1:0] op_code, input logic [PAT_W-1:0] bits,
			input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		op           <= op_code;
		pattern_bits <= bits;
		row_index    <= row;
		col_index    <= col;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_results.push_back(step_engine(op_code, bits, row, col));
	endtask

	task automatic send_query(input int row, input int col);
		send_item(OP_QUERY, random_word(), row[IDX_W-1:0], col[IDX_W-1:0]);
	endtask

	task automatic send_load(input logic [PAT_W-1:0] bits);
		send_item(OP_LOAD, bits, IDX_W'($urandom), IDX_W'($urandom));
	endtask

	// Stops offering items and waits until every owed result has come back.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Only called with the engine idle.
	task automatic write_neuron_count(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		neuron_setting = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Receiver and result checking
	// ------------------------------------------------------------------------

	// The receiver stalls at random; a requested hold-off takes priority and
	// keeps ready low for a counted number of cycles.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (!steady_flow && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
			end
		end
	end

	// Every result transfer is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		weight_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: sum %0d weight %0d status %0d",
					overlap_sum, weight_fixed, status));
			end else begin
				want = pending_results.pop_front();
				if (overlap_sum !== want.sum) begin
					report_mismatch($sformatf("overlap_sum %0d, expected %0d",
						overlap_sum, $signed(want.sum)));
				end
				if (weight_fixed !== want.weight) begin
					report_mismatch($sformatf("weight_fixed %0d, expected %0d",
						weight_fixed, $signed(want.weight)));
				end
				if (status !== want.stat) begin
					report_mismatch($sformatf("status %0d, expected %0d", status, want.stat));
				end
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Hand-picked items on the reset neuron count of 64: an empty store, the
	// extreme patterns, the diagonal, the spare op code and a clear.
	task automatic test_directed();
		send_query(0, 1);
		send_item(OP_CLEAR, '1, '1, '1);
		send_load('1);
		send_load('0);
		send_load(ALT_ODD);
		send_load(ALT_EVEN);
		send_query(0, 1);
		send_query(0, 2);
		send_query(63, 0);
		send_query(63, 1);
		send_query(1, 0);
		send_query(5, 5);
		send_item(2'd3, '1, '1, '1);
		send_load(64'h8000_0000_0000_0001);
		send_query(0, 63);
		send_query(62, 63);
		send_query(63, 62);
		send_item(OP_CLEAR, '0, '0, '0);
		send_query(0, 1);
		send_query(63, 63);
		wait_drain();
	endtask

	// Fills the store with one alternating pattern, so that even neurons are
	// always +1 and odd ones always -1, then tries to load past the end.
	task automatic test_store_full();
		send_item(OP_CLEAR, random_word(), '0, '0);
		repeat (MAX_PATTERNS) begin
			send_load(ALT_EVEN);
		end
		send_load('1);
		send_load('0);
		send_query(0, 1);
		send_query(0, 2);
		send_query(63, 61);
		send_query(62, 63);
		wait_drain();
	endtask

	// Walks the neuron count through its extremes on the full store. A count
	// of two gives the largest weight magnitude the engine can produce.
	task automatic test_neuron_count();
		write_neuron_count(7'd2);
		send_query(0, 1);
		send_query(1, 0);
		send_query(0, 0);
		send_query(2, 0);
		wait_drain();
		// Zero behaves as a count of one.
		write_neuron_count(7'd0);
		send_query(0, 0);
		send_query(0, 1);
		send_query(1, 0);
		wait_drain();
		write_neuron_count(7'd1);
		send_query(0, 1);
		send_query(0, 0);
		wait_drain();
		// Anything above the array size is clamped to it.
		write_neuron_count(7'd127);
		send_query(63, 0);
		send_query(62, 0);
		wait_drain();
		// An odd divisor exercises truncation toward zero.
		write_neuron_count(7'd37);
		send_query(36, 1);
		send_query(36, 0);
		send_query(37, 0);
		send_query(0, 37);
		wait_drain();
		write_neuron_count(7'd64);
	endtask

	// The receiver holds off for a long stretch while queries keep coming,
	// so the engine fills up and drops in_ready; then the sender pauses
	// until every result is back.
	task automatic test_backpressure();
		wait_drain();
		hold_left = HOLD_CYCLES;
		steady_flow = 1'b1;
		repeat (10) begin
			send_query($urandom_range(0, 63), $urandom_range(0, 63));
		end
		steady_flow = 1'b0;
		wait_drain();
	endtask

	// Random sequences: mostly clear, load a cluster of patterns, then query
	// in range; the rest is unstructured noise over all op codes.
	task automatic test_random_sequences();
		int sent;
		int kind;
		int loads;
		int n;
		int row;
		int col;
		logic [PAT_W-1:0] base;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady_flow = ($urandom_range(0, 9) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				wait_drain();
				write_neuron_count(random_neuron_count());
			end
			if (kind < 75) begin
				if ($urandom_range(0, 9) < 7) begin
					send_item(OP_CLEAR, random_word(), IDX_W'($urandom), IDX_W'($urandom));
					sent++;
				end
				// Now and then a long run of loads can reach the full store.
				loads = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 16);
				base = random_word();
				repeat (loads) begin
					send_load(related_pattern(base));
					sent++;
				end
				n = active_neurons();
				repeat ($urandom_range(4, 20)) begin
					if ($urandom_range(0, 9) == 0) begin
						row = $urandom_range(0, 63);
						col = $urandom_range(0, 63);
					end else begin
						row = $urandom_range(0, n - 1);
						col = ($urandom_range(0, 99) < 15) ? row : $urandom_range(0, n - 1);
					end
					send_query(row, col);
					sent++;
				end
			end else begin
				repeat ($urandom_range(3, 12)) begin
					send_item(OP_W'($urandom_range(0, 3)), random_word(),
						IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)));
					sent++;
				end
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		// Every input starts at a known value before the first edge.
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		op             = OP_CLEAR;
		pattern_bits   = '0;
		row_index      = '0;
		col_index      = '0;
		out_ready      = 1'b0;
		mismatch_count = 0;
		hold_left      = 0;
		stall_left     = 0;
		steady_flow    = 1'b0;
		pattern_total  = 0;
		neuron_setting = NCOUNT_RESET;
		for (int j = 0; j < MAX_NEURONS; j++) begin
			column_words[j] = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_store_full();
		test_neuron_count();
		test_backpressure();
		test_random_sequences();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> files.f
design/hwe_pkg.sv
design/hwe_pat_mem.sv
design/hwe_serial_div.sv
design/hebbian_weight_engine_top.sv
tb/hebbian_weight_engine_top_tb.sv
